>>> sv/bvps_pkg.sv
// Shared types and constants for the battery voltage power sequencer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package bvps_pkg;

   // Width of a Q8.8 level and of the wait timers.
   localparam int LEVEL_W = 16;
   localparam int SAMPLE_W = 8;
   localparam int BURST_W = 8;

   // Samples fed to the smoothing filter per burst, and the filter divisor.
   localparam int SAMPLES_PER_BURST = 150;
   localparam int FILTER_DIVISOR = 20;

   // Reciprocal used to divide a 16-bit magnitude by the filter divisor:
   // q = (n * FILTER_RECIP) >> FILTER_SHIFT, exact for all n below 2**16.
   localparam int FILTER_SHIFT = LEVEL_W + $clog2(FILTER_DIVISOR);
   localparam int FILTER_RECIP = ((2 ** FILTER_SHIFT) + FILTER_DIVISOR - 1) / FILTER_DIVISOR;
   localparam int RECIP_W = LEVEL_W + 1;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ON_COUNT_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OFF_COUNT_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_TICKS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PULSE_TICKS = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SETTLE_TICKS = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_WAIT_TICKS = 3'd7;

   // Register values after reset.
   localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD_RST = 16'd49766;
   localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RST = 16'd49229;
   localparam logic [3:0] ON_COUNT_LIMIT_RST = 4'd2;
   localparam logic [5:0] OFF_COUNT_LIMIT_RST = 6'd35;
   localparam logic [LEVEL_W-1:0] BLINK_TICKS_RST = 16'd200;
   localparam logic [LEVEL_W-1:0] PULSE_TICKS_RST = 16'd4000;
   localparam logic [LEVEL_W-1:0] SETTLE_TICKS_RST = 16'd35000;
   localparam logic [LEVEL_W-1:0] LOW_WAIT_TICKS_RST = 16'd5000;

   typedef struct packed {
      logic [LEVEL_W-1:0] high_threshold;
      logic [LEVEL_W-1:0] low_threshold;
      logic [3:0]         on_count_limit;
      logic [5:0]         off_count_limit;
      logic [LEVEL_W-1:0] blink_ticks;
      logic [LEVEL_W-1:0] pulse_ticks;
      logic [LEVEL_W-1:0] settle_ticks;
      logic [LEVEL_W-1:0] low_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic               led_on;
      logic               adapter_power;
      logic               host_shutdown;
      logic               want_sample;
      logic [LEVEL_W-1:0] filtered_level;
   } result_type;

endpackage

`default_nettype wire

>>> sv/bvps_if.sv
// Valid/ready channel interfaces for the request (sample or tick) and response items.
// Depends on bvps_pkg for the field widths.
`default_nettype none

interface bvps_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [bvps_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output command, output sample, input ready);
   modport sink (input valid, input command, input sample, output ready);
endinterface

interface bvps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         led_on;
   logic                         adapter_power;
   logic                         host_shutdown;
   logic                         want_sample;
   logic [bvps_pkg::LEVEL_W-1:0] filtered_level;

   modport source (output valid, output led_on, output adapter_power, output host_shutdown,
                   output want_sample, output filtered_level, input ready);
   modport sink (input valid, input led_on, input adapter_power, input host_shutdown,
                 input want_sample, input filtered_level, output ready);
endinterface

`default_nettype wire

>>> sv/bvps_filter.sv
// First-order smoothing filter step: v + ((x << 8) - v) / divisor, truncated toward zero.
// Depends on bvps_pkg for widths and the reciprocal of the divisor.
`default_nettype none

module bvps_filter (
   input  wire logic [bvps_pkg::LEVEL_W-1:0]  level,
   input  wire logic [bvps_pkg::SAMPLE_W-1:0] sample,
   output logic      [bvps_pkg::LEVEL_W-1:0]  next_level
);

   localparam int W = bvps_pkg::LEVEL_W;
   localparam int PROD_W = W + bvps_pkg::RECIP_W;

   logic [W:0]        diff;
   logic              negative;
   logic [W-1:0]      magnitude;
   logic [PROD_W-1:0] product;
   logic [W-1:0]      quotient;

   // Difference is a signed value one bit wider than the level.
   assign diff = {1'b0, sample, {(W - bvps_pkg::SAMPLE_W){1'b0}}} - {1'b0, level};
   assign negative = diff[W];
   // The magnitude never exceeds 65535, so the low bits carry it whole.
   assign magnitude = negative ? W'(-diff) : diff[W-1:0];
   assign product = PROD_W'(magnitude) * PROD_W'(bvps_pkg::FILTER_RECIP);
   assign quotient = W'(product >> bvps_pkg::FILTER_SHIFT);
   assign next_level = negative ? (level - quotient) : (level + quotient);

endmodule

`default_nettype wire

>>> sv/bvps_ctrl.sv
// Phase machine, wait timer, burst counter, streak counters and output pins.
// Depends on bvps_pkg and instantiates bvps_filter.
`default_nettype none

module bvps_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic                          command,
   input  wire logic [bvps_pkg::SAMPLE_W-1:0] sample,
   input  wire bvps_pkg::cfg_type             cfg,
   output bvps_pkg::result_type               result
);

   localparam int W = bvps_pkg::LEVEL_W;

   localparam logic [2:0] PH_BLINK = 3'd0;
   localparam logic [2:0] PH_SAMPLE = 3'd1;
   localparam logic [2:0] PH_LOWWAIT = 3'd2;
   localparam logic [2:0] PH_PULSE = 3'd3;
   localparam logic [2:0] PH_SETTLE = 3'd4;

   logic [2:0]                   phase_ff, phase_in;
   logic [W-1:0]                 timer_ff, timer_in;
   logic [bvps_pkg::BURST_W-1:0] burst_ff, burst_in;
   logic [W-1:0]                 level_ff, level_in;
   logic [4:0]                   high_streak_ff, high_streak_in;
   logic [6:0]                   low_streak_ff, low_streak_in;
   logic                         running_ff, running_in;
   logic                         led_ff, led_in;
   logic                         adapter_ff, adapter_in;
   logic                         host_ff, host_in;

   logic [W-1:0]                 filt_level;
   logic [W-1:0]                 timer_next;
   logic [bvps_pkg::BURST_W-1:0] burst_next;
   logic                         go;
   logic [2:0]                   go_phase;

   bvps_filter u_filter (
      .level      (level_ff),
      .sample     (sample),
      .next_level (filt_level)
   );

   // The wait timer saturates at its full scale.
   assign timer_next = (timer_ff != {W{1'b1}}) ? (timer_ff + W'(1)) : timer_ff;
   assign burst_next = burst_ff + bvps_pkg::BURST_W'(1);

   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      burst_in = burst_ff;
      level_in = level_ff;
      high_streak_in = high_streak_ff;
      low_streak_in = low_streak_ff;
      running_in = running_ff;
      led_in = led_ff;
      adapter_in = adapter_ff;
      host_in = host_ff;
      go = 1'b0;
      go_phase = PH_BLINK;

      if (fire) begin
         if (phase_ff == PH_SAMPLE) begin
            if (!command) begin
               level_in = filt_level;
               burst_in = burst_next;
               // The last sample of a burst also runs the evaluation.
               if (burst_next >= bvps_pkg::BURST_W'(bvps_pkg::SAMPLES_PER_BURST)) begin
                  go = 1'b1;
                  if (filt_level <= cfg.low_threshold) begin
                     if (low_streak_ff > {1'b0, cfg.off_count_limit}) begin
                        high_streak_in = '0;
                        low_streak_in = '0;
                        if (running_ff) begin
                           host_in = 1'b1;
                           go_phase = PH_PULSE;
                        end
                     end else begin
                        if (low_streak_ff != 7'h7F) begin
                           low_streak_in = low_streak_ff + 7'd1;
                        end
                        high_streak_in = '0;
                        go_phase = PH_LOWWAIT;
                     end
                  end else if (filt_level > cfg.high_threshold) begin
                     if (high_streak_ff > {1'b0, cfg.on_count_limit}) begin
                        if (!running_ff) begin
                           adapter_in = 1'b1;
                           running_in = 1'b1;
                        end
                        high_streak_in = '0;
                     end else begin
                        if (high_streak_ff != 5'h1F) begin
                           high_streak_in = high_streak_ff + 5'd1;
                        end
                        low_streak_in = '0;
                     end
                  end else begin
                     high_streak_in = '0;
                     low_streak_in = '0;
                  end
               end
            end
         end else if (command) begin
            timer_in = timer_next;
            case (phase_ff)
               PH_LOWWAIT: begin
                  if (timer_next >= cfg.low_wait_ticks) begin
                     go = 1'b1;
                  end
               end
               PH_PULSE: begin
                  if (timer_next >= cfg.pulse_ticks) begin
                     host_in = 1'b0;
                     go = 1'b1;
                     go_phase = PH_SETTLE;
                  end
               end
               PH_SETTLE: begin
                  if (timer_next >= cfg.settle_ticks) begin
                     adapter_in = 1'b0;
                     running_in = 1'b0;
                     go = 1'b1;
                  end
               end
               default: begin
                  // Blink wait, and any code never entered.
                  if (timer_next >= cfg.blink_ticks) begin
                     led_in = 1'b1;
                     go = 1'b1;
                     go_phase = PH_SAMPLE;
                  end
               end
            endcase
         end
      end

      // Entering a phase restarts the timer and the burst count.
      if (go) begin
         phase_in = go_phase;
         timer_in = '0;
         burst_in = '0;
         if (go_phase == PH_BLINK || go_phase == PH_LOWWAIT) begin
            led_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BLINK;
         timer_ff <= '0;
         burst_ff <= '0;
         level_ff <= '0;
         high_streak_ff <= '0;
         low_streak_ff <= '0;
         running_ff <= 1'b0;
         led_ff <= 1'b0;
         adapter_ff <= 1'b0;
         host_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         burst_ff <= burst_in;
         level_ff <= level_in;
         high_streak_ff <= high_streak_in;
         low_streak_ff <= low_streak_in;
         running_ff <= running_in;
         led_ff <= led_in;
         adapter_ff <= adapter_in;
         host_ff <= host_in;
      end
   end

   assign result.led_on = led_in;
   assign result.adapter_power = adapter_in;
   assign result.host_shutdown = host_in;
   assign result.want_sample = (phase_in == PH_SAMPLE);
   assign result.filtered_level = level_in;

endmodule

`default_nettype wire

>>> sv/battery_voltage_power_sequencer.sv
// Top level of the battery voltage power sequencer: channels, configuration registers,
// input and result registers. Depends on bvps_pkg, bvps_if and bvps_ctrl.
//
// How the block is used:
// Each transfer on the request channel carries one item: a command bit (0 = ADC sample,
// 1 = one millisecond tick) and an 8-bit sample. Every request yields exactly one
// transfer on the response channel showing the LED, adapter and host shutdown pins,
// whether the block now wants samples, and the filtered level in Q8.8.
// A request transfer lands in an input register; when the result register is empty or
// being drained, the phase machine updates its state from it and the response is
// written to the result register. The block takes one item per cycle for as long as
// the receiver keeps up; the rate rests on the state update, which needs one
// divide-by-constant multiply for the filter.
// When the receiver stalls, the result register holds its item and the input register
// can still take one more transfer; request ready drops only when both are full.
// The configuration port writes one register per cycle with write enable, index and
// data; it should only be written while no items are in flight.
// Synchronous reset puts all configuration registers at their default values, empties
// both stages, drops all output pins, clears the filter and starts in the blink wait phase.
`default_nettype none

module battery_voltage_power_sequencer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bvps_req_if.sink                              req_chan,
   bvps_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_write_enable,
   input  wire logic [bvps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bvps_pkg::LEVEL_W-1:0]     csr_write_data
);

   bvps_pkg::cfg_type    cfg_ff, cfg_in;
   bvps_pkg::result_type result_ff, result_in;
   bvps_pkg::result_type ctrl_result;

   logic                          in_valid_ff, in_valid_in;
   logic                          command_ff;
   logic [bvps_pkg::SAMPLE_W-1:0] sample_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          advance;
   logic                          fire;
   logic                          req_take;

   // The result stage can take a new item when it is empty or being drained.
   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign fire = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_chan.ready);
   assign result_in = fire ? ctrl_result : result_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            bvps_pkg::REG_HIGH_THRESHOLD:  cfg_in.high_threshold = csr_write_data;
            bvps_pkg::REG_LOW_THRESHOLD:   cfg_in.low_threshold = csr_write_data;
            bvps_pkg::REG_ON_COUNT_LIMIT:  cfg_in.on_count_limit = csr_write_data[3:0];
            bvps_pkg::REG_OFF_COUNT_LIMIT: cfg_in.off_count_limit = csr_write_data[5:0];
            bvps_pkg::REG_BLINK_TICKS:     cfg_in.blink_ticks = csr_write_data;
            bvps_pkg::REG_PULSE_TICKS:     cfg_in.pulse_ticks = csr_write_data;
            bvps_pkg::REG_SETTLE_TICKS:    cfg_in.settle_ticks = csr_write_data;
            bvps_pkg::REG_LOW_WAIT_TICKS:  cfg_in.low_wait_ticks = csr_write_data;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_threshold <= bvps_pkg::HIGH_THRESHOLD_RST;
         cfg_ff.low_threshold <= bvps_pkg::LOW_THRESHOLD_RST;
         cfg_ff.on_count_limit <= bvps_pkg::ON_COUNT_LIMIT_RST;
         cfg_ff.off_count_limit <= bvps_pkg::OFF_COUNT_LIMIT_RST;
         cfg_ff.blink_ticks <= bvps_pkg::BLINK_TICKS_RST;
         cfg_ff.pulse_ticks <= bvps_pkg::PULSE_TICKS_RST;
         cfg_ff.settle_ticks <= bvps_pkg::SETTLE_TICKS_RST;
         cfg_ff.low_wait_ticks <= bvps_pkg::LOW_WAIT_TICKS_RST;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         command_ff <= req_chan.command;
         sample_ff <= req_chan.sample;
      end
      result_ff <= result_in;
   end

   bvps_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .command (command_ff),
      .sample  (sample_ff),
      .cfg     (cfg_ff),
      .result  (ctrl_result)
   );

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.led_on = result_ff.led_on;
   assign rsp_chan.adapter_power = result_ff.adapter_power;
   assign rsp_chan.host_shutdown = result_ff.host_shutdown;
   assign rsp_chan.want_sample = result_ff.want_sample;
   assign rsp_chan.filtered_level = result_ff.filtered_level;

endmodule

`default_nettype wire

>>> sim/bvps_sequence_checker.sv
// Response checker for the battery voltage power sequencer: follows the phase machine,
// filter and pin levels, and compares every response transfer against its prediction.
// Depends on bvps_pkg and on the request and response interfaces in bvps_if.
`timescale 1ns / 100ps

module bvps_sequence_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bvps_req_if                                   req_mon,
   bvps_rsp_if                                   rsp_mon,
   input  wire logic                             csr_write_enable,
   input  wire logic [bvps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bvps_pkg::LEVEL_W-1:0]     csr_write_data,
   output int                                    mismatches,
   output int                                    outstanding,
   output int                                    checked,
   output int                                    switch_ons,
   output int                                    shutdown_pulses
);

   typedef enum logic [2:0] {
      BLINK_WAIT,
      SAMPLING,
      LOW_WAIT,
      SHUTDOWN_PULSE,
      SETTLE_WAIT
   } seq_phase_type;

   bvps_pkg::cfg_type            settings;
   seq_phase_type                phase;
   logic [bvps_pkg::LEVEL_W-1:0] wait_count;
   logic [bvps_pkg::LEVEL_W-1:0] level;
   logic [bvps_pkg::BURST_W-1:0] burst_count;
   logic [4:0]                   high_streak;
   logic [6:0]                   low_streak;
   logic                         host_up;
   logic                         led;
   logic                         adapter;
   logic                         host_req;
   bvps_pkg::result_type         expected_outputs[$];

   task automatic restart_model();
      settings.high_threshold = bvps_pkg::HIGH_THRESHOLD_RST;
      settings.low_threshold = bvps_pkg::LOW_THRESHOLD_RST;
      settings.on_count_limit = bvps_pkg::ON_COUNT_LIMIT_RST;
      settings.off_count_limit = bvps_pkg::OFF_COUNT_LIMIT_RST;
      settings.blink_ticks = bvps_pkg::BLINK_TICKS_RST;
      settings.pulse_ticks = bvps_pkg::PULSE_TICKS_RST;
      settings.settle_ticks = bvps_pkg::SETTLE_TICKS_RST;
      settings.low_wait_ticks = bvps_pkg::LOW_WAIT_TICKS_RST;
      phase = BLINK_WAIT;
      wait_count = '0;
      burst_count = '0;
      level = '0;
      high_streak = '0;
      low_streak = '0;
      host_up = 1'b0;
      led = 1'b0;
      adapter = 1'b0;
      host_req = 1'b0;
   endtask

   task automatic enter_phase(input seq_phase_type target_phase);
      phase = target_phase;
      wait_count = '0;
      burst_count = '0;
      if (target_phase == BLINK_WAIT || target_phase == LOW_WAIT) begin
         led = 1'b0;
      end
   endtask

   // Counts one tick of a wait; the timer saturates rather than wrapping.
   function automatic logic wait_over(input logic [bvps_pkg::LEVEL_W-1:0] span);
      if (wait_count != '1) begin
         wait_count = wait_count + 1'b1;
      end
      return wait_count >= span;
   endfunction

   // Decision taken on the last sample of a burst. The low test comes first, so
   // crossed thresholds count as low.
   task automatic judge_level();
      if (level <= settings.low_threshold) begin
         if (low_streak > settings.off_count_limit) begin
            high_streak = '0;
            low_streak = '0;
            if (host_up) begin
               host_req = 1'b1;
               shutdown_pulses++;
               enter_phase(SHUTDOWN_PULSE);
            end else begin
               enter_phase(BLINK_WAIT);
            end
         end else begin
            if (low_streak != '1) begin
               low_streak++;
            end
            high_streak = '0;
            enter_phase(LOW_WAIT);
         end
      end else if (level > settings.high_threshold) begin
         if (high_streak > settings.on_count_limit) begin
            if (!host_up) begin
               adapter = 1'b1;
               host_up = 1'b1;
               switch_ons++;
            end
            high_streak = '0;
         end else begin
            if (high_streak != '1) begin
               high_streak++;
            end
            low_streak = '0;
         end
         enter_phase(BLINK_WAIT);
      end else begin
         high_streak = '0;
         low_streak = '0;
         enter_phase(BLINK_WAIT);
      end
   endtask

   task automatic apply_item(input logic is_tick, input logic [bvps_pkg::SAMPLE_W-1:0] smp);
      int step_to_sample;
      if (phase == SAMPLING) begin
         if (!is_tick) begin
            // Signed difference, quotient truncated toward zero.
            step_to_sample = int'({smp, 8'h00}) - int'(level);
            level = bvps_pkg::LEVEL_W'(int'(level) + step_to_sample / bvps_pkg::FILTER_DIVISOR);
            burst_count++;
            if (burst_count >= bvps_pkg::SAMPLES_PER_BURST) begin
               judge_level();
            end
         end
      end else if (is_tick) begin
         case (phase)
            LOW_WAIT: begin
               if (wait_over(settings.low_wait_ticks)) begin
                  enter_phase(BLINK_WAIT);
               end
            end
            SHUTDOWN_PULSE: begin
               if (wait_over(settings.pulse_ticks)) begin
                  host_req = 1'b0;
                  enter_phase(SETTLE_WAIT);
               end
            end
            SETTLE_WAIT: begin
               if (wait_over(settings.settle_ticks)) begin
                  adapter = 1'b0;
                  host_up = 1'b0;
                  enter_phase(BLINK_WAIT);
               end
            end
            default: begin
               if (wait_over(settings.blink_ticks)) begin
                  led = 1'b1;
                  enter_phase(SAMPLING);
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      bvps_pkg::result_type seen;
      bvps_pkg::result_type want;
      if (reset) begin
         restart_model();
         expected_outputs.delete();
         mismatches = 0;
         checked = 0;
         switch_ons = 0;
         shutdown_pulses = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.led_on = rsp_mon.led_on;
            seen.adapter_power = rsp_mon.adapter_power;
            seen.host_shutdown = rsp_mon.host_shutdown;
            seen.want_sample = rsp_mon.want_sample;
            seen.filtered_level = rsp_mon.filtered_level;
            checked++;
            if (expected_outputs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: extra response led %0b adapter %0b host %0b want %0b level %0d",
                           $time, seen.led_on, seen.adapter_power, seen.host_shutdown,
                           seen.want_sample, seen.filtered_level);
               end
            end else begin
               want = expected_outputs.pop_front();
               if (seen.led_on !== want.led_on || seen.adapter_power !== want.adapter_power ||
                   seen.host_shutdown !== want.host_shutdown ||
                   seen.want_sample !== want.want_sample ||
                   seen.filtered_level !== want.filtered_level) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: expected led %0b adapter %0b host %0b want %0b level %0d",
                              $time, want.led_on, want.adapter_power, want.host_shutdown,
                              want.want_sample, want.filtered_level);
                     $display("%0t:      got led %0b adapter %0b host %0b want %0b level %0d",
                              $time, seen.led_on, seen.adapter_power, seen.host_shutdown,
                              seen.want_sample, seen.filtered_level);
                  end
               end
            end
         end

         if (csr_write_enable) begin
            case (csr_index)
               bvps_pkg::REG_HIGH_THRESHOLD:  settings.high_threshold = csr_write_data;
               bvps_pkg::REG_LOW_THRESHOLD:   settings.low_threshold = csr_write_data;
               bvps_pkg::REG_ON_COUNT_LIMIT:  settings.on_count_limit = csr_write_data[3:0];
               bvps_pkg::REG_OFF_COUNT_LIMIT: settings.off_count_limit = csr_write_data[5:0];
               bvps_pkg::REG_BLINK_TICKS:     settings.blink_ticks = csr_write_data;
               bvps_pkg::REG_PULSE_TICKS:     settings.pulse_ticks = csr_write_data;
               bvps_pkg::REG_SETTLE_TICKS:    settings.settle_ticks = csr_write_data;
               bvps_pkg::REG_LOW_WAIT_TICKS:  settings.low_wait_ticks = csr_write_data;
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            apply_item(req_mon.command, req_mon.sample);
            want.led_on = led;
            want.adapter_power = adapter;
            want.host_shutdown = host_req;
            want.want_sample = (phase == SAMPLING);
            want.filtered_level = level;
            expected_outputs.push_back(want);
         end
      end
      outstanding = expected_outputs.size();
   end

endmodule

>>> sim/battery_voltage_power_sequencer_test.sv
// Testbench top for the battery voltage power sequencer: clock, reset, register writes
// and sample/tick stimulus with random pacing; the verdict comes from bvps_sequence_checker.
// Depends on bvps_pkg, bvps_if, the block itself and bvps_sequence_checker.
`timescale 1ns / 100ps

module battery_voltage_power_sequencer_test;

   // The limit is set above the slowest correct run, in which every transfer meets
   // the longest gap on both sides.
   localparam int CYCLE_LIMIT = 1_000_000;
   // The block registers each response in its result register; TAIL_CYCLES of quiet
   // follow the last response before any register write or the verdict.
   localparam int TAIL_CYCLES = 6;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [bvps_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bvps_pkg::LEVEL_W-1:0]     csr_write_data;

   bvps_req_if req_bus ();
   bvps_rsp_if rsp_bus ();

   int mismatches;
   int outstanding;
   int checked;
   int switch_ons;
   int shutdown_pulses;
   int settings_applied;
   int cycle_count;

   // req_fire: a request transfer happened at the last rising edge.
   // in_sampling: the last response said the block wants samples; it steers the
   // stimulus so that most bursts land whole in the sampling phase.
   // quiet: while set, neither side inserts gaps.
   logic              req_fire;
   logic              in_sampling;
   logic              quiet;
   bvps_pkg::cfg_type setting;

   battery_voltage_power_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bvps_sequence_checker response_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .checked          (checked),
      .switch_ons       (switch_ons),
      .shutdown_pulses  (shutdown_pulses)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake or a missing response ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Everything the stimulus reacts to is captured at the rising edge, before the
   // block's registers update, and read back at the falling edge.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         in_sampling <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            in_sampling <= rsp_bus.want_sample;
         end
      end
   end

   // Gap lengths: mostly none, some short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 65) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 12);
      end else begin
         return $urandom_range(20, 60);
      end
   endfunction

   // Receiver: ready drops for random stretches, so responses back up into the
   // block and request ready drops in turn.
   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   // Offers one item and returns at the falling edge after its transfer. Valid is
   // left high so that a following item goes out back to back.
   task automatic send_item(input logic command_code,
                            input logic [bvps_pkg::SAMPLE_W-1:0] smp);
      req_bus.valid <= 1'b1;
      req_bus.command <= command_code;
      req_bus.sample <= smp;
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_bus.valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Holds the sender off until every predicted response has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   // Writes all eight registers, one per cycle. With pad_limits the unused upper
   // bits of the two count limits are written as ones, which the block must drop.
   task automatic write_settings(input bvps_pkg::cfg_type next_cfg, input logic pad_limits);
      logic [bvps_pkg::LEVEL_W-1:0] data;
      logic [bvps_pkg::LEVEL_W-1:0] pad;
      pad = pad_limits ? '1 : '0;
      for (int i = 0; i < 8; i++) begin
         case (bvps_pkg::CSR_INDEX_W'(i))
            bvps_pkg::REG_HIGH_THRESHOLD:  data = next_cfg.high_threshold;
            bvps_pkg::REG_LOW_THRESHOLD:   data = next_cfg.low_threshold;
            bvps_pkg::REG_ON_COUNT_LIMIT:  data = {pad[15:4], next_cfg.on_count_limit};
            bvps_pkg::REG_OFF_COUNT_LIMIT: data = {pad[15:6], next_cfg.off_count_limit};
            bvps_pkg::REG_BLINK_TICKS:     data = next_cfg.blink_ticks;
            bvps_pkg::REG_PULSE_TICKS:     data = next_cfg.pulse_ticks;
            bvps_pkg::REG_SETTLE_TICKS:    data = next_cfg.settle_ticks;
            bvps_pkg::REG_LOW_WAIT_TICKS:  data = next_cfg.low_wait_ticks;
            default:                       data = '0;
         endcase
         csr_write_enable <= 1'b1;
         csr_index <= bvps_pkg::CSR_INDEX_W'(i);
         csr_write_data <= data;
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
      setting = next_cfg;
      settings_applied++;
   endtask

   // Closed-loop stimulus: ticks while the block waits, then samples while it
   // samples, each burst aimed at one level (above, between or below the
   // thresholds) so that streaks build up and the power and shutdown paths run.
   // About one item in twelve is noise: a random command and a random sample.
   // Only items the block acts on count toward the quota.
   task automatic run_phase(input int quota);
      int                            effective;
      int                            run_left;
      int                            roll;
      int                            level_goal;
      int                            pick;
      int                            hi8;
      int                            lo8;
      logic                          goal_set;
      logic                          is_tick;
      logic [bvps_pkg::SAMPLE_W-1:0] smp;
      effective = 0;
      run_left = 0;
      roll = 0;
      level_goal = 0;
      goal_set = 1'b0;
      while (effective < quota) begin
         if ($urandom_range(0, 99) < 8) begin
            is_tick = 1'($urandom_range(0, 1));
            smp = bvps_pkg::SAMPLE_W'($urandom);
         end else if (in_sampling) begin
            if (!goal_set) begin
               // A mode holds for one to three bursts so that streaks can grow.
               if (run_left == 0) begin
                  roll = $urandom_range(0, 99);
                  run_left = $urandom_range(1, 3);
               end
               run_left--;
               hi8 = int'(setting.high_threshold[15:8]);
               lo8 = int'(setting.low_threshold[15:8]);
               if (roll < 40) begin
                  level_goal = (hi8 >= 253) ? 255 : int'($urandom_range(hi8 + 2, 255));
               end else if (roll < 75) begin
                  level_goal = (lo8 < 3) ? 0 : int'($urandom_range(0, lo8 - 3));
               end else if (roll < 90) begin
                  level_goal = (hi8 + lo8) / 2;
               end else begin
                  level_goal = $urandom_range(0, 255);
               end
               goal_set = 1'b1;
            end
            is_tick = 1'b0;
            pick = level_goal + int'($urandom_range(0, 4)) - 2;
            smp = (pick < 0) ? '0 : (pick > 255) ? '1 : bvps_pkg::SAMPLE_W'(pick);
         end else begin
            is_tick = 1'b1;
            smp = bvps_pkg::SAMPLE_W'($urandom);
            goal_set = 1'b0;
         end
         if (is_tick != in_sampling) begin
            effective++;
         end
         send_item(is_tick ? CMD_TICK : CMD_SAMPLE, smp);
         pause_sender(pick_gap());
         if ($urandom_range(0, 149) == 0) begin
            quiet <= ~quiet;
         end
      end
   endtask

   initial begin
      bvps_pkg::cfg_type plan;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_SAMPLE;
      req_bus.sample = '0;
      quiet = 1'b0;
      settings_applied = 0;
      setting.high_threshold = bvps_pkg::HIGH_THRESHOLD_RST;
      setting.low_threshold = bvps_pkg::LOW_THRESHOLD_RST;
      setting.on_count_limit = bvps_pkg::ON_COUNT_LIMIT_RST;
      setting.off_count_limit = bvps_pkg::OFF_COUNT_LIMIT_RST;
      setting.blink_ticks = bvps_pkg::BLINK_TICKS_RST;
      setting.pulse_ticks = bvps_pkg::PULSE_TICKS_RST;
      setting.settle_ticks = bvps_pkg::SETTLE_TICKS_RST;
      setting.low_wait_ticks = bvps_pkg::LOW_WAIT_TICKS_RST;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Straight out of reset the block sits in the blink wait with its default
      // registers: stray samples must be ignored and ticks only advance the timer.
      send_item(CMD_SAMPLE, 8'hFF);
      send_item(CMD_SAMPLE, 8'h00);
      send_item(CMD_TICK, 8'h55);
      send_item(CMD_TICK, 8'hAA);
      drain();

      // Longest waits: a couple of ticks must not end the blink wait.
      plan = setting;
      plan.blink_ticks = '1;
      plan.pulse_ticks = '1;
      plan.settle_ticks = '1;
      plan.low_wait_ticks = '1;
      write_settings(plan, 1'b0);
      send_item(CMD_TICK, 8'h0F);
      send_item(CMD_TICK, 8'hF0);
      drain();

      // Zero-length waits: the next tick ends the blink wait that is already
      // running and lights the LED. A tick during sampling is then ignored, and
      // full-scale samples in both directions exercise the filter's signed step.
      plan.high_threshold = 16'h8000;
      plan.low_threshold = 16'h4000;
      plan.on_count_limit = '0;
      plan.off_count_limit = '0;
      plan.blink_ticks = '0;
      plan.pulse_ticks = '0;
      plan.settle_ticks = '0;
      plan.low_wait_ticks = '0;
      write_settings(plan, 1'b0);
      send_item(CMD_TICK, 8'h00);
      send_item(CMD_TICK, 8'hFF);
      send_item(CMD_SAMPLE, 8'hFF);
      send_item(CMD_SAMPLE, 8'h00);
      send_item(CMD_SAMPLE, 8'h80);
      send_item(CMD_SAMPLE, 8'h7F);
      send_item(CMD_SAMPLE, 8'h01);
      drain();

      // Default thresholds, shortest streaks and short waits: two high bursts
      // switch the adapter on, two low ones send the shutdown pulse.
      plan.high_threshold = bvps_pkg::HIGH_THRESHOLD_RST;
      plan.low_threshold = bvps_pkg::LOW_THRESHOLD_RST;
      plan.blink_ticks = 16'd2;
      plan.pulse_ticks = 16'd3;
      plan.settle_ticks = 16'd4;
      plan.low_wait_ticks = 16'd1;
      write_settings(plan, 1'b0);
      run_phase(350);
      drain();

      // Wide band between the thresholds, streak limits of one, no waits at all.
      plan.high_threshold = 16'h9600;
      plan.low_threshold = 16'h6400;
      plan.on_count_limit = 4'd1;
      plan.off_count_limit = 6'd1;
      plan.blink_ticks = '0;
      plan.pulse_ticks = '0;
      plan.settle_ticks = '0;
      plan.low_wait_ticks = '0;
      write_settings(plan, 1'b0);
      run_phase(250);
      drain();

      // Crossed thresholds (low above high), so the low case wins; the limits
      // go to their maximum through writes with ones in the unused bits.
      plan.high_threshold = 16'h3000;
      plan.low_threshold = 16'hC000;
      plan.on_count_limit = '1;
      plan.off_count_limit = '1;
      plan.blink_ticks = 16'd1;
      plan.pulse_ticks = 16'd2;
      plan.settle_ticks = 16'd1;
      plan.low_wait_ticks = 16'd3;
      write_settings(plan, 1'b1);
      run_phase(150);
      drain();

      // Both thresholds at zero: any nonzero level is high, so the adapter comes on.
      plan.high_threshold = '0;
      plan.low_threshold = '0;
      plan.on_count_limit = '0;
      plan.off_count_limit = '0;
      plan.blink_ticks = 16'd1;
      plan.pulse_ticks = 16'd2;
      plan.settle_ticks = 16'd3;
      plan.low_wait_ticks = 16'd1;
      write_settings(plan, 1'b0);
      run_phase(380);
      drain();

      // Both thresholds at full scale: every level is low, which shuts the host
      // down and then drops the adapter.
      plan.high_threshold = '1;
      plan.low_threshold = '1;
      write_settings(plan, 1'b0);
      run_phase(380);
      drain();

      $display("Run covered %0d response transfers under %0d register settings.",
               checked, settings_applied);
      $display("Adapter switched on %0d times; the host saw %0d shutdown pulses.",
               switch_ons, shutdown_pulses);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
